// ===== rtl/smqe_pkg.sv =====
`default_nettype none

package smqe_pkg;

    localparam int QUEUE_DEPTH     = 16;
    localparam int STEP_COUNT_BITS = 16;
    localparam int NUM_AXES        = 4;
    localparam int SLOT_BITS       = $clog2(QUEUE_DEPTH);
    localparam int AXIS_BITS       = 2;
    localparam int KIND_BITS       = 2;
    localparam int FIELD_BITS      = 16;
    localparam int DELAY_BITS      = 16;
    localparam int PERIOD_BITS     = 16;
    localparam int TICKS_BITS      = 8;
    localparam int POL_BITS        = 4;
    localparam int MOVE_INDEX_BITS = 4;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 8;

    typedef logic [SLOT_BITS-1:0]       t_slot;
    typedef logic [STEP_COUNT_BITS-1:0] t_step_cnt;
    typedef logic [DELAY_BITS-1:0]      t_delay;
    typedef logic [PERIOD_BITS-1:0]     t_period;
    typedef logic [AXIS_BITS-1:0]       t_axis;
    typedef logic [KIND_BITS-1:0]       t_kind;
    typedef logic [TICKS_BITS-1:0]      t_ticks;
    typedef logic [POL_BITS-1:0]        t_pol;
    typedef logic [CFG_INDEX_BITS-1:0]  t_cfg_index;
    typedef logic [CFG_DATA_BITS-1:0]   t_cfg_data;

    localparam t_kind KIND_PUSH  = 2'd0;
    localparam t_kind KIND_TICK  = 2'd1;
    localparam t_kind KIND_START = 2'd2;

    localparam t_cfg_index CFG_POLARITY = 1'd0;
    localparam t_cfg_index CFG_TICKS    = 1'd1;

    localparam t_ticks TICKS_RESET = 8'd6;

    typedef struct packed {
        logic [NUM_AXES-1:0] fwd;
        logic                stop;
        logic                occ;
    } t_flags;

    typedef struct packed {
        t_flags                   flags;
        t_step_cnt [NUM_AXES-1:0] steps;
        t_delay    [NUM_AXES-1:0] delays;
    } t_entry;

    typedef struct packed {
        logic  we;
        t_slot waddr;
        t_entry wdata;
        logic  re;
        t_slot raddr;
    } t_ram_req;

    typedef struct packed {
        t_kind                  kind;
        t_axis                  axis;
        logic [FIELD_BITS-1:0]  steps_x;
        logic [FIELD_BITS-1:0]  steps_y;
        logic [FIELD_BITS-1:0]  steps_z;
        logic [FIELD_BITS-1:0]  steps_e;
        logic [NUM_AXES-1:0]    dir_positive_mask;
        t_delay                 delay_x;
        t_delay                 delay_y;
        t_delay                 delay_z;
        t_delay                 delay_e;
        logic                   stop_motors_after;
    } t_in_item;

    typedef struct packed {
        logic                       step_valid;
        t_axis                      step_axis;
        logic                       step_dir;
        logic                       advanced;
        logic [MOVE_INDEX_BITS-1:0] move_index;
        logic [NUM_AXES-1:0]        reload_mask;
        t_period                    period_x;
        t_period                    period_y;
        t_period                    period_z;
        t_period                    period_e;
        logic                       motors_enabled;
        logic                       push_accepted;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_NEXT,
        S_RELOAD,
        S_OUT
    } t_state;

    function automatic t_slot next_slot(input t_slot s);
        if (s == t_slot'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return t_slot'(s + 1'b1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/smqe_entry_ram.sv =====
`default_nettype none

module smqe_entry_ram (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire smqe_pkg::t_ram_req i_req,
    output smqe_pkg::t_entry       o_rdata
);

    logic [smqe_pkg::QUEUE_DEPTH-1:0] r_valid;
    smqe_pkg::t_entry                 r_mem [smqe_pkg::QUEUE_DEPTH];
    smqe_pkg::t_entry                 r_rdata;
    logic                             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvalid <= r_valid[i_req.raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

`default_nettype wire

// ===== rtl/smqe_period.sv =====
`default_nettype none

module smqe_period (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_load,
    input  wire smqe_pkg::t_delay [smqe_pkg::NUM_AXES-1:0] i_delays,
    input  wire smqe_pkg::t_ticks                        i_ticks,
    output smqe_pkg::t_period [smqe_pkg::NUM_AXES-1:0]   o_periods,
    output logic [smqe_pkg::NUM_AXES-1:0]                o_mask
);

    localparam int PROD_BITS = smqe_pkg::DELAY_BITS + smqe_pkg::TICKS_BITS;

    logic [PROD_BITS-1:0]                            prod [smqe_pkg::NUM_AXES];
    smqe_pkg::t_period [smqe_pkg::NUM_AXES-1:0]      n_periods;
    logic [smqe_pkg::NUM_AXES-1:0]                   n_mask;
    smqe_pkg::t_period [smqe_pkg::NUM_AXES-1:0]      r_periods;
    logic [smqe_pkg::NUM_AXES-1:0]                   r_mask;

    always_comb begin
        for (int a = 0; a < smqe_pkg::NUM_AXES; a++) begin
            prod[a]      = PROD_BITS'(i_delays[a]) * PROD_BITS'(i_ticks);
            n_periods[a] = prod[a][smqe_pkg::PERIOD_BITS-1:0];
            n_mask[a]    = (i_delays[a] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_periods <= n_periods;
            r_mask    <= n_mask;
        end
    end

    assign o_periods = r_periods;
    assign o_mask    = r_mask;

endmodule

`default_nettype wire

// ===== rtl/stepper_move_queue_executor_unit.sv =====
`default_nettype none

// One item is taken at a time. A push, an ignored item or a start while running goes
// straight to its result; a tick or first start reads the running entry first. Results
// appear as the next item can be taken. The longest tick frees its entry and reloads the
// periods of an occupied successor. A result held by the receiver stalls the next item at
// its end. The entry memory has one read and one write port with a registered read.
// Synchronous active-low reset empties the queue and stops the executor at once.
module stepper_move_queue_executor_unit (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire smqe_pkg::t_in_item     i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output smqe_pkg::t_out_item         o_out_data,
    input  wire logic                   i_cfg_we,
    input  wire smqe_pkg::t_cfg_index   i_cfg_index,
    input  wire smqe_pkg::t_cfg_data    i_cfg_data
);

    smqe_pkg::t_state    r_state;
    smqe_pkg::t_state    n_state;
    smqe_pkg::t_in_item  r_item;
    smqe_pkg::t_in_item  n_item;
    smqe_pkg::t_slot     r_run_slot;
    smqe_pkg::t_slot     n_run_slot;
    smqe_pkg::t_slot     r_fill_slot;
    smqe_pkg::t_slot     n_fill_slot;
    logic                r_running;
    logic                n_running;
    logic                r_motors_on;
    logic                n_motors_on;
    smqe_pkg::t_pol      r_polarity;
    smqe_pkg::t_ticks    r_ticks;
    smqe_pkg::t_out_item r_res;
    smqe_pkg::t_out_item n_res;
    logic                r_out_valid;
    logic                n_out_valid;
    smqe_pkg::t_out_item r_out;
    smqe_pkg::t_out_item n_out;

    smqe_pkg::t_ram_req  ram_req;
    smqe_pkg::t_entry    ent;
    smqe_pkg::t_entry    push_entry;
    smqe_pkg::t_entry    tick_entry;
    smqe_pkg::t_step_cnt cur_steps;
    smqe_pkg::t_slot     nx_run;
    smqe_pkg::t_slot     nx_fill;
    logic                accept;
    logic                can_step;
    logic                complete;
    logic                out_free;
    logic                period_load;
    smqe_pkg::t_period [smqe_pkg::NUM_AXES-1:0] periods;
    logic [smqe_pkg::NUM_AXES-1:0]              reload_mask;

    smqe_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ent)
    );

    smqe_period u_period (
        .i_clk     (i_clk),
        .i_load    (period_load),
        .i_delays  (ent.delays),
        .i_ticks   (r_ticks),
        .o_periods (periods),
        .o_mask    (reload_mask)
    );

    assign o_in_stall  = (r_state != smqe_pkg::S_IDLE);
    assign accept      = i_in_valid && (r_state == smqe_pkg::S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign nx_run      = smqe_pkg::next_slot(r_run_slot);
    assign nx_fill     = smqe_pkg::next_slot(r_fill_slot);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        push_entry.flags.fwd  = i_in_data.dir_positive_mask ^ r_polarity;
        push_entry.flags.stop = i_in_data.stop_motors_after;
        push_entry.flags.occ  = 1'b1;
        push_entry.steps[0]   = smqe_pkg::t_step_cnt'(i_in_data.steps_x);
        push_entry.steps[1]   = smqe_pkg::t_step_cnt'(i_in_data.steps_y);
        push_entry.steps[2]   = smqe_pkg::t_step_cnt'(i_in_data.steps_z);
        push_entry.steps[3]   = smqe_pkg::t_step_cnt'(i_in_data.steps_e);
        push_entry.delays[0]  = i_in_data.delay_x;
        push_entry.delays[1]  = i_in_data.delay_y;
        push_entry.delays[2]  = i_in_data.delay_z;
        push_entry.delays[3]  = i_in_data.delay_e;
    end

    always_comb begin
        cur_steps  = ent.steps[r_item.axis];
        can_step   = r_running && (cur_steps != '0);
        tick_entry = ent;
        if (can_step) begin
            tick_entry.steps[r_item.axis] = smqe_pkg::t_step_cnt'(cur_steps - 1'b1);
        end
        complete = (tick_entry.steps == '0);
        if (complete) begin
            tick_entry.flags.occ = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smqe_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_in_data.kind)
                        smqe_pkg::KIND_TICK:  n_state = smqe_pkg::S_EXEC;
                        smqe_pkg::KIND_START: begin
                            n_state = r_running ? smqe_pkg::S_OUT : smqe_pkg::S_EXEC;
                        end
                        default:              n_state = smqe_pkg::S_OUT;
                    endcase
                end
            end
            smqe_pkg::S_EXEC: begin
                if (r_item.kind == smqe_pkg::KIND_START) begin
                    n_state = smqe_pkg::S_RELOAD;
                end else if (complete && (nx_run != r_fill_slot)) begin
                    n_state = smqe_pkg::S_NEXT;
                end else begin
                    n_state = smqe_pkg::S_OUT;
                end
            end
            smqe_pkg::S_NEXT: begin
                n_state = ent.flags.occ ? smqe_pkg::S_RELOAD : smqe_pkg::S_OUT;
            end
            smqe_pkg::S_RELOAD: n_state = smqe_pkg::S_OUT;
            smqe_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = smqe_pkg::S_IDLE;
                end
            end
            default: n_state = smqe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_item      = r_item;
        n_run_slot  = r_run_slot;
        n_fill_slot = r_fill_slot;
        n_running   = r_running;
        n_motors_on = r_motors_on;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        period_load = 1'b0;
        ram_req     = '0;
        unique case (r_state)
            smqe_pkg::S_IDLE: begin
                if (accept) begin
                    n_item = i_in_data;
                    n_res  = '0;
                    case (i_in_data.kind)
                        smqe_pkg::KIND_PUSH: begin
                            if (nx_fill != r_run_slot) begin
                                ram_req.we          = 1'b1;
                                ram_req.waddr       = r_fill_slot;
                                ram_req.wdata       = push_entry;
                                n_fill_slot         = nx_fill;
                                n_res.push_accepted = 1'b1;
                            end
                        end
                        smqe_pkg::KIND_TICK: begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = r_run_slot;
                        end
                        smqe_pkg::KIND_START: begin
                            if (!r_running) begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = r_run_slot;
                                n_running     = 1'b1;
                                n_motors_on   = 1'b1;
                            end
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end
            smqe_pkg::S_EXEC: begin
                if (r_item.kind == smqe_pkg::KIND_START) begin
                    period_load = 1'b1;
                end else begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_run_slot;
                    ram_req.wdata = tick_entry;
                    if (can_step) begin
                        n_res.step_valid = 1'b1;
                        n_res.step_axis  = r_item.axis;
                        n_res.step_dir   = ent.flags.fwd[r_item.axis];
                    end
                    if (complete) begin
                        if (ent.flags.stop) begin
                            n_motors_on = 1'b0;
                        end
                        if (nx_run != r_fill_slot) begin
                            n_res.advanced = 1'b1;
                            n_run_slot     = nx_run;
                            ram_req.re     = 1'b1;
                            ram_req.raddr  = nx_run;
                        end
                    end
                end
            end
            smqe_pkg::S_NEXT: begin
                period_load = ent.flags.occ;
            end
            smqe_pkg::S_RELOAD: begin
                n_res.reload_mask = reload_mask;
                n_res.period_x    = periods[0];
                n_res.period_y    = periods[1];
                n_res.period_z    = periods[2];
                n_res.period_e    = periods[3];
            end
            smqe_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out                = r_res;
                    n_out.move_index     = smqe_pkg::MOVE_INDEX_BITS'(r_run_slot);
                    n_out.motors_enabled = r_motors_on;
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smqe_pkg::S_IDLE;
            r_run_slot  <= '0;
            r_fill_slot <= smqe_pkg::next_slot('0);
            r_running   <= 1'b0;
            r_motors_on <= 1'b0;
            r_out_valid <= 1'b0;
            r_polarity  <= '0;
            r_ticks     <= smqe_pkg::TICKS_RESET;
        end else begin
            r_state     <= n_state;
            r_run_slot  <= n_run_slot;
            r_fill_slot <= n_fill_slot;
            r_running   <= n_running;
            r_motors_on <= n_motors_on;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    smqe_pkg::CFG_POLARITY: r_polarity <= i_cfg_data[smqe_pkg::POL_BITS-1:0];
                    smqe_pkg::CFG_TICKS:    r_ticks    <= i_cfg_data[smqe_pkg::TICKS_BITS-1:0];
                    default:                r_ticks    <= r_ticks;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    a_slots_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_slot != r_fill_slot)
        else $error("running slot and fill slot coincide");

    a_running_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |=> r_running)
        else $error("running flag was cleared");

    a_reload_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smqe_pkg::S_RELOAD) |->
            ($past(r_state) == smqe_pkg::S_EXEC || $past(r_state) == smqe_pkg::S_NEXT))
        else $error("period reload without a preceding entry read");
`endif

endmodule

`default_nettype wire
